>>> rtl/core/lps_pkg.sv
package lps_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int IDX_W        = 32;
	localparam int SCALE_W      = 16;
	localparam int TIME_W       = 48;
	localparam int CFG_W        = 32;
	localparam int CHANNELS_DEF = 16;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_LEVEL_CARE  = 3'd0,
		REG_LEVEL_VALUE = 3'd1,
		REG_EDGE_RISE   = 3'd2,
		REG_EDGE_FALL   = 3'd3,
		REG_RANGE_START = 3'd4,
		REG_RANGE_END   = 3'd5,
		REG_TIME_SCALE  = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] level_care;
		logic [SAMPLE_W-1:0] level_value;
		logic [SAMPLE_W-1:0] edge_rise;
		logic [SAMPLE_W-1:0] edge_fall;
		logic [IDX_W-1:0]    range_start;
		logic [IDX_W-1:0]    range_end;
	} lps_cfg_t;

	// one pending match, still in sample indices
	typedef struct packed {
		logic [IDX_W-1:0] first_idx;
		logic [IDX_W:0]   last_idx;   // at most range_end when the final sample closes a run
		logic             dec;        // subtract one time unit from the scaled end
	} lps_res_t;

endpackage

>>> rtl/core/lps_match.sv
module lps_match
	import lps_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lps_cfg_t            cfg,
	input  logic                sample_valid,
	output logic                sample_ready,
	input  logic [SAMPLE_W-1:0] sample_bits,
	input  logic                final_sample,
	output logic                valid_s1,
	output lps_res_t            res_s1,
	input  logic                ready_s1
);

	localparam int ACT = (CHANNELS < SAMPLE_W) ? CHANNELS : SAMPLE_W;

	logic [ACT-1:0]   prev_q;
	logic [IDX_W-1:0] count_q;
	logic             run_open_q;
	logic [IDX_W-1:0] run_begin_q;

	logic [ACT-1:0] cur, rise, fall, edges, lev, ok;
	logic           edge_mode, level_ok, edge_hit, lvl_match, take, hit;
	lps_res_t       res;

	assign cur   = sample_bits[ACT-1:0];
	assign rise  = cfg.edge_rise[ACT-1:0];
	assign fall  = cfg.edge_fall[ACT-1:0];
	assign edges = rise | fall;
	assign lev   = cfg.level_care[ACT-1:0] & ~edges;

	assign edge_mode = |edges;
	assign level_ok  = ((cur ^ cfg.level_value[ACT-1:0]) & lev) == '0;

	// per channel: both bits = any change, else the chosen direction
	assign ok = (rise & fall & (prev_q ^ cur))
		| (rise & ~fall & ~prev_q & cur)
		| (fall & ~rise & prev_q & ~cur);

	assign edge_hit = (ok == edges) && level_ok
		&& (count_q > cfg.range_start) && (count_q <= cfg.range_end);

	assign lvl_match = (|lev) && level_ok
		&& (count_q >= cfg.range_start) && (count_q < cfg.range_end);

	always_comb begin
		res.first_idx = count_q;
		res.last_idx  = {1'b0, count_q};
		res.dec       = 1'b0;
		hit           = 1'b0;
		if (edge_mode) begin
			hit = edge_hit;
		end else if (lvl_match) begin
			if (run_open_q) begin
				res.first_idx = run_begin_q;
			end
			res.last_idx = {1'b0, count_q} + {{IDX_W{1'b0}}, 1'b1};
			res.dec      = 1'b1;
			hit          = final_sample;
		end else begin
			res.first_idx = run_begin_q;
			res.dec       = 1'b1;
			hit           = run_open_q;
		end
	end

	assign sample_ready = !valid_s1 || ready_s1;
	assign take         = sample_valid && sample_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			count_q     <= '0;
			run_open_q  <= 1'b0;
			run_begin_q <= '0;
			valid_s1    <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= hit;
				if (final_sample) begin
					prev_q     <= '0;
					count_q    <= '0;
					run_open_q <= 1'b0;
				end else begin
					prev_q  <= cur;
					count_q <= count_q + {{(IDX_W-1){1'b0}}, 1'b1};
					if (edge_mode) begin
						run_open_q <= 1'b0;
					end else if (lvl_match) begin
						run_open_q <= 1'b1;
					end else begin
						run_open_q <= 1'b0;
					end
				end
				if (!edge_mode && lvl_match && !run_open_q) begin
					run_begin_q <= count_q;
				end
			end else if (ready_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_s1 <= res;
		end
	end

endmodule

>>> rtl/core/lps_scale.sv
module lps_scale
	import lps_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [SCALE_W-1:0] scale,
	input  logic               valid_s1,
	input  lps_res_t           res_s1,
	output logic               ready_s1,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [TIME_W-1:0]  first_time,
	output logic [TIME_W-1:0]  last_time
);

	logic [TIME_W-1:0]  first_prod;
	logic [TIME_W:0]    last_prod;
	logic [TIME_W-1:0]  last_calc;

	assign first_prod = TIME_W'(res_s1.first_idx) * TIME_W'(scale);
	assign last_prod  = (TIME_W+1)'(res_s1.last_idx) * (TIME_W+1)'(scale);
	assign last_calc  = last_prod[TIME_W-1:0] - {{(TIME_W-1){1'b0}}, res_s1.dec};

	assign ready_s1 = !result_valid || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (ready_s1) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && valid_s1) begin
			first_time <= first_prod;
			last_time  <= last_calc;
		end
	end

endmodule

>>> rtl/core/logic_pattern_search.sv
// Pattern and edge trigger over a stream of logic-analyzer samples. Each request
// on the sample channel is one captured sample (bit i = channel i); samples are
// numbered from 0 and the count restarts after a request marked final_sample.
// With no edge channels configured the block reports each maximal run of samples
// whose cared channels hold their levels, inside range_start <= i < range_end;
// otherwise it reports each sample where every edge channel makes its selected
// transition and the level channels match, inside range_start < i <= range_end.
// Times are sample index times time_scale (0 acts as 1), modulo 2^48. The block
// takes one sample per clock while sample_ready is high; the result of the sample
// that closes a match passes the match/state stage, then the scaling multiplier
// stage that feeds the output register. Configuration writes belong to idle time.
module logic_pattern_search
	import lps_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration write port
	input  logic                wr_en,
	input  logic [2:0]          wr_index,
	input  logic [CFG_W-1:0]    wr_data,
	// sample requests
	input  logic                sample_valid,
	output logic                sample_ready,
	input  logic [SAMPLE_W-1:0] sample_bits,
	input  logic                final_sample,
	// match results
	output logic                result_valid,
	input  logic                result_ready,
	output logic [TIME_W-1:0]   first_time,
	output logic [TIME_W-1:0]   last_time
);

	localparam int ACT = (CHANNELS < SAMPLE_W) ? CHANNELS : SAMPLE_W;

	lps_cfg_t           cfg_q;
	logic [SCALE_W-1:0] time_scale_q;
	logic [SCALE_W-1:0] scale;
	logic               valid_s1, ready_s1;
	lps_res_t           res_s1;
	logic               edge_mode;

	// register file; indexes past the list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level_care  <= '0;
			cfg_q.level_value <= '0;
			cfg_q.edge_rise   <= '0;
			cfg_q.edge_fall   <= '0;
			cfg_q.range_start <= '0;
			cfg_q.range_end   <= '1;
			time_scale_q      <= {{(SCALE_W-1){1'b0}}, 1'b1};
		end else if (wr_en) begin
			unique case (wr_index)
				REG_LEVEL_CARE:  cfg_q.level_care  <= wr_data[SAMPLE_W-1:0];
				REG_LEVEL_VALUE: cfg_q.level_value <= wr_data[SAMPLE_W-1:0];
				REG_EDGE_RISE:   cfg_q.edge_rise   <= wr_data[SAMPLE_W-1:0];
				REG_EDGE_FALL:   cfg_q.edge_fall   <= wr_data[SAMPLE_W-1:0];
				REG_RANGE_START: cfg_q.range_start <= wr_data[IDX_W-1:0];
				REG_RANGE_END:   cfg_q.range_end   <= wr_data[IDX_W-1:0];
				REG_TIME_SCALE:  time_scale_q      <= wr_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// a zero scale behaves as one
	assign scale = (time_scale_q == '0) ? {{(SCALE_W-1){1'b0}}, 1'b1} : time_scale_q;

	// edge mode as seen on the examined channels
	assign edge_mode = |(cfg_q.edge_rise[ACT-1:0] | cfg_q.edge_fall[ACT-1:0]);

	// stage 1: run/edge detection and sample state
	lps_match #(
		.CHANNELS(CHANNELS)
	) u_match (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample_bits  (sample_bits),
		.final_sample (final_sample),
		.valid_s1     (valid_s1),
		.res_s1       (res_s1),
		.ready_s1     (ready_s1)
	);

	// stage 2: index to time, into the output register
	lps_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.scale        (scale),
		.valid_s1     (valid_s1),
		.res_s1       (res_s1),
		.ready_s1     (ready_s1),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.first_time   (first_time),
		.last_time    (last_time)
	);

	// input only stalls when both stages are full and the output is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> (valid_s1 && result_valid && !result_ready))
		else $error("sample channel stalled without a blocked result");

	// edge results are single points
	a_edge_point: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && edge_mode) |-> (first_time == last_time))
		else $error("edge result with differing first and last time");

	// a pending stage 1 result moves on whenever the output register frees
	a_s1_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && ready_s1) |=> result_valid)
		else $error("stage 1 result lost on its way to the output");

endmodule

>>> tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lps_pkg::*;

	// index 7 is outside the register map; writes there must be ignored
	localparam logic [2:0] REG_UNUSED = 3'd7;

	localparam int RANDOM_SETTINGS = 27;
	localparam int SAMPLES_PER_SETTING = 50;

	typedef struct {
		logic [SAMPLE_W-1:0] bits;
		logic                fin;
	} sample_t;

	typedef struct {
		logic [TIME_W-1:0] first_t;
		logic [TIME_W-1:0] last_t;
	} match_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                wr_en = 1'b0;
	logic [2:0]          wr_index = '0;
	logic [CFG_W-1:0]    wr_data = '0;
	logic                sample_valid = 1'b0;
	logic                sample_ready;
	logic [SAMPLE_W-1:0] sample_bits = '0;
	logic                final_sample = 1'b0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	logic [TIME_W-1:0]   first_time;
	logic [TIME_W-1:0]   last_time;

	logic_pattern_search dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample_bits  (sample_bits),
		.final_sample (final_sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.first_time   (first_time),
		.last_time    (last_time)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow copy of the register file, reset values
	logic [SAMPLE_W-1:0] cfg_care  = '0;
	logic [SAMPLE_W-1:0] cfg_value = '0;
	logic [SAMPLE_W-1:0] cfg_rise  = '0;
	logic [SAMPLE_W-1:0] cfg_fall  = '0;
	logic [IDX_W-1:0]    cfg_start = '0;
	logic [IDX_W-1:0]    cfg_end   = '1;
	logic [SCALE_W-1:0]  cfg_scale = 16'd1;

	// predictor state
	logic [SAMPLE_W-1:0] prev_bits  = '0;
	logic [IDX_W-1:0]    sample_idx = '0;
	logic                in_run     = 1'b0;
	logic [IDX_W-1:0]    run_from   = '0;

	sample_t pending_samples[$];
	match_t  expected_matches[$];

	// last sample queued, so the generator can shape edges against it
	logic [SAMPLE_W-1:0] gen_prev = '0;

	bit src_idle = 1'b0;
	bit snk_idle = 1'b0;
	int src_gap;
	int snk_stall;
	int samples_sent = 0;
	int matches_seen = 0;
	int fail_count = 0;
	int edge_settings = 0;
	int level_settings = 0;

	sample_t drv_req;
	match_t  want_match;

	// sample index -> time units, scale 0 acting as 1, kept to 48 bits
	function automatic logic [TIME_W-1:0] to_time(input logic [IDX_W:0] idx);
		logic [63:0] prod;
		prod = 64'(idx) * 64'((cfg_scale == '0) ? 16'd1 : cfg_scale);
		return prod[TIME_W-1:0];
	endfunction

	// advance the expected search state by one accepted sample and queue
	// whatever match it completes
	function automatic void predict_sample(input logic [SAMPLE_W-1:0] bits, input logic fin);
		logic [SAMPLE_W-1:0] edges, lev, up, down, flip, both, ok;
		logic                level_ok, hit;
		match_t              m;
		edges    = cfg_rise | cfg_fall;
		lev      = cfg_care & ~edges;
		level_ok = ((bits ^ cfg_value) & lev) == '0;
		if (edges != '0) begin
			up   = ~prev_bits & bits;
			down = prev_bits & ~bits;
			flip = prev_bits ^ bits;
			both = cfg_rise & cfg_fall;
			ok   = (both & flip) | (cfg_rise & ~cfg_fall & up) | (cfg_fall & ~cfg_rise & down);
			// any open level run is abandoned once edge mode sees a sample
			in_run = 1'b0;
			if (ok == edges && level_ok && sample_idx > cfg_start && sample_idx <= cfg_end) begin
				m.first_t = to_time({1'b0, sample_idx});
				m.last_t  = m.first_t;
				expected_matches.push_back(m);
			end
		end else begin
			hit = lev != '0 && level_ok && sample_idx >= cfg_start && sample_idx < cfg_end;
			if (hit) begin
				if (!in_run) begin
					in_run   = 1'b1;
					run_from = sample_idx;
				end
				// final sample closes the run and is part of it
				if (fin) begin
					m.first_t = to_time({1'b0, run_from});
					m.last_t  = to_time({1'b0, sample_idx} + 33'd1) - 48'd1;
					expected_matches.push_back(m);
				end
			end else if (in_run) begin
				m.first_t = to_time({1'b0, run_from});
				m.last_t  = to_time({1'b0, sample_idx}) - 48'd1;
				expected_matches.push_back(m);
				in_run = 1'b0;
			end
		end
		if (fin) begin
			prev_bits  = '0;
			sample_idx = '0;
			in_run     = 1'b0;
		end else begin
			prev_bits  = bits;
			sample_idx = sample_idx + 32'd1;
		end
	endfunction

	// mostly back-to-back, some short pauses, rarely a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_mask();
		logic [SAMPLE_W-1:0] m;
		int n;
		m = '0;
		case ($urandom_range(0, 9))
		0: m = 16'hFFFF;
		1: m = 16'($urandom);
		2: m = '0;
		default: begin
			n = $urandom_range(1, 3);
			repeat (n) m[$urandom_range(0, 15)] = 1'b1;
		end
		endcase
		return m;
	endfunction

	// one register write per clock; 16-bit registers get junk in the upper half
	task automatic set_reg(input logic [2:0] idx, input logic [CFG_W-1:0] v);
		logic [CFG_W-1:0] data;
		data = v;
		if (idx != REG_RANGE_START && idx != REG_RANGE_END)
			data[31:16] = 16'($urandom);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		case (idx)
		REG_LEVEL_CARE:  cfg_care  = data[15:0];
		REG_LEVEL_VALUE: cfg_value = data[15:0];
		REG_EDGE_RISE:   cfg_rise  = data[15:0];
		REG_EDGE_FALL:   cfg_fall  = data[15:0];
		REG_RANGE_START: cfg_start = data;
		REG_RANGE_END:   cfg_end   = data;
		REG_TIME_SCALE:  cfg_scale = data[15:0];
		default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic push_sample(input logic [SAMPLE_W-1:0] bits, input logic fin);
		sample_t s;
		s.bits = bits;
		s.fin  = fin;
		pending_samples.push_back(s);
		gen_prev = fin ? '0 : bits;
	endtask

	// hold off until every request is taken and every match is back, then
	// give the two-stage pipe time to settle a run that is still open;
	// queue and valid are looked at on the falling edge, once the driver
	// and monitor have settled
	task automatic wait_quiet();
		int spin;
		spin = 0;
		@(negedge clk);
		while (pending_samples.size() != 0 || sample_valid)
			@(negedge clk);
		while (expected_matches.size() != 0 && spin < 100000) begin
			@(negedge clk);
			spin++;
		end
		repeat (5) @(posedge clk);
	endtask

	// sample request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample_bits  <= '0;
			final_sample <= 1'b0;
			src_gap      <= 0;
		end else begin
			if (sample_valid && sample_ready) begin
				predict_sample(sample_bits, final_sample);
				samples_sent++;
			end
			if (!sample_valid || sample_ready) begin
				if (src_gap > 0) begin
					src_gap      <= src_gap - 1;
					sample_valid <= 1'b0;
				end else if (pending_samples.size() != 0) begin
					drv_req = pending_samples.pop_front();
					sample_bits  <= drv_req.bits;
					final_sample <= drv_req.fin;
					sample_valid <= 1'b1;
					src_gap      <= src_idle ? pick_gap() : 0;
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// match monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			snk_stall    <= 0;
		end else begin
			if (result_valid && result_ready) begin
				matches_seen++;
				if (expected_matches.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected match: first %h last %h", first_time, last_time);
				end else begin
					want_match = expected_matches.pop_front();
					if (want_match.first_t !== first_time || want_match.last_t !== last_time) begin
						fail_count++;
						if (fail_count <= 10)
							$display("match %0d: first exp %h got %h, last exp %h got %h",
								matches_seen, want_match.first_t, first_time,
								want_match.last_t, last_time);
					end
				end
			end
			if (snk_stall > 0) begin
				result_ready <= 1'b0;
				snk_stall    <= snk_stall - 1;
			end else begin
				result_ready <= 1'b1;
				snk_stall    <= snk_idle ? pick_gap() : 0;
			end
		end
	end

	initial begin
		int phase, j, k, r, ch;
		logic [SAMPLE_W-1:0] edges, lev, both, tgt, bits, rise_m, fall_m;
		logic [IDX_W-1:0] lo, hi;
		logic fin;

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset settings have no level channels: nothing to report
		push_sample(16'hFFFF, 1'b0);
		push_sample(16'h0000, 1'b0);
		wait_quiet();

		// every channel cared, largest scale; one run closed by a miss,
		// one closed by the final sample
		set_reg(REG_LEVEL_CARE, 32'hFFFF);
		set_reg(REG_LEVEL_VALUE, 32'hFFFF);
		set_reg(REG_TIME_SCALE, 32'hFFFF);
		end_writes();
		push_sample(16'hFFFF, 1'b0);
		push_sample(16'hFFFF, 1'b0);
		push_sample(16'h0000, 1'b0);
		push_sample(16'hFFFF, 1'b1);
		wait_quiet();

		// zero scale, run cut by the end of a [1,3) window
		set_reg(REG_TIME_SCALE, 32'h0);
		set_reg(REG_LEVEL_CARE, 32'h0001);
		set_reg(REG_LEVEL_VALUE, 32'h0000);
		set_reg(REG_RANGE_START, 32'd1);
		set_reg(REG_RANGE_END, 32'd3);
		end_writes();
		push_sample(16'hFFFE, 1'b0);
		push_sample(16'h0000, 1'b0);
		push_sample(16'hFFFE, 1'b0);
		push_sample(16'h0000, 1'b0);
		push_sample(16'hFFFF, 1'b1);
		wait_quiet();

		// open a run, then move to edge mode: the run is dropped silently
		set_reg(REG_RANGE_START, 32'd0);
		set_reg(REG_RANGE_END, 32'hFFFF_FFFF);
		end_writes();
		push_sample(16'h0000, 1'b0);
		push_sample(16'h0000, 1'b0);
		wait_quiet();
		// ch0 rise, ch1 fall, ch2 either, ch15 held high
		set_reg(REG_EDGE_RISE, 32'h0005);
		set_reg(REG_EDGE_FALL, 32'h0006);
		set_reg(REG_LEVEL_CARE, 32'h8000);
		set_reg(REG_LEVEL_VALUE, 32'h8000);
		set_reg(REG_TIME_SCALE, 32'd7);
		set_reg(REG_UNUSED, $urandom);
		end_writes();
		push_sample(16'h8002, 1'b0);
		push_sample(16'h8005, 1'b0);
		push_sample(16'h0002, 1'b0);
		wait_quiet();
		set_reg(REG_EDGE_RISE, 32'h0);
		set_reg(REG_EDGE_FALL, 32'h0);
		set_reg(REG_LEVEL_CARE, 32'h0001);
		set_reg(REG_LEVEL_VALUE, 32'h0000);
		end_writes();
		push_sample(16'h0001, 1'b1);
		wait_quiet();

		// reversed window: edges happen but nothing is inside
		set_reg(REG_EDGE_RISE, 32'h0001);
		set_reg(REG_RANGE_START, 32'hFFFF_FFFF);
		set_reg(REG_RANGE_END, 32'h0);
		end_writes();
		push_sample(16'h0001, 1'b0);
		push_sample(16'h0000, 1'b0);
		push_sample(16'h0001, 1'b1);
		wait_quiet();

		// edge window (1,2]: index 0 excluded, index 2 taken, index 4 outside
		set_reg(REG_RANGE_START, 32'd1);
		set_reg(REG_RANGE_END, 32'd2);
		end_writes();
		push_sample(16'h0001, 1'b0);
		push_sample(16'h0000, 1'b0);
		push_sample(16'h0001, 1'b0);
		push_sample(16'h0000, 1'b0);
		push_sample(16'h0001, 1'b1);
		wait_quiet();

		// random settings, each followed by a burst of shaped samples
		for (phase = 0; phase < RANDOM_SETTINGS; phase++) begin
			r = $urandom_range(0, 9);
			if (r < 5) begin
				rise_m = '0;
				fall_m = '0;
			end else if (r < 9) begin
				rise_m = '0;
				fall_m = '0;
				k = $urandom_range(1, 3);
				for (j = 0; j < k; j++) begin
					ch = $urandom_range(0, 15);
					case ($urandom_range(0, 2))
					0: rise_m[ch] = 1'b1;
					1: fall_m[ch] = 1'b1;
					default: begin
						rise_m[ch] = 1'b1;
						fall_m[ch] = 1'b1;
					end
					endcase
				end
			end else begin
				rise_m = 16'($urandom);
				fall_m = 16'($urandom);
			end
			set_reg(REG_EDGE_RISE, {16'h0, rise_m});
			set_reg(REG_EDGE_FALL, {16'h0, fall_m});
			set_reg(REG_LEVEL_CARE, {16'h0, pick_mask()});
			set_reg(REG_LEVEL_VALUE, $urandom);

			case ($urandom_range(0, 7))
			0: begin
				lo = '0;
				hi = '1;
			end
			1: begin
				lo = '1;
				hi = '0;
			end
			2: begin
				lo = $urandom_range(0, 40);
				hi = $urandom_range(0, lo);
			end
			default: begin
				lo = $urandom_range(0, 15);
				hi = lo + $urandom_range(1, 60);
			end
			endcase
			set_reg(REG_RANGE_START, lo);
			set_reg(REG_RANGE_END, hi);

			case ($urandom_range(0, 7))
			0: set_reg(REG_TIME_SCALE, 32'h0);
			1: set_reg(REG_TIME_SCALE, 32'h1);
			2: set_reg(REG_TIME_SCALE, 32'hFFFF);
			default: set_reg(REG_TIME_SCALE, $urandom_range(1, 65535));
			endcase
			if ($urandom_range(0, 7) == 0)
				set_reg(REG_UNUSED, $urandom);
			end_writes();

			if ((cfg_rise | cfg_fall) != '0)
				edge_settings++;
			else
				level_settings++;
			src_idle = $urandom_range(0, 3) != 0;
			snk_idle = $urandom_range(0, 3) != 0;

			edges = cfg_rise | cfg_fall;
			lev   = cfg_care & ~edges;
			both  = cfg_rise & cfg_fall;
			for (j = 0; j < SAMPLES_PER_SETTING; j++) begin
				bits = 16'($urandom);
				r = $urandom_range(0, 9);
				if (edges == '0) begin
					// level mode: mostly hold the pattern so runs build up
					if (r < 8)
						bits = (bits & ~lev) | (cfg_value & lev);
				end else if (r < 8) begin
					if (r < 4)
						// complete every edge against the previous sample
						tgt = (cfg_rise & ~cfg_fall) | (both & ~gen_prev);
					else
						// arm the channels for the next edge
						tgt = (cfg_fall & ~cfg_rise) | (both & bits);
					bits = (bits & ~edges) | (tgt & edges);
					if (r != 3)
						bits = (bits & ~lev) | (cfg_value & lev);
				end
				fin = $urandom_range(0, 24) == 0;
				push_sample(bits, fin);
			end
			wait_quiet();
		end

		if (expected_matches.size() != 0) begin
			fail_count += expected_matches.size();
			$display("%0d matches never arrived", expected_matches.size());
		end
		$display("Covered %0d sample requests and %0d matches over %0d random settings",
			samples_sent, matches_seen, RANDOM_SETTINGS);
		$display("(%0d in edge mode, %0d in level mode), %0d errors",
			edge_settings, level_settings, fail_count);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout: %0d requests taken, %0d matches outstanding",
			samples_sent, expected_matches.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> files.f
rtl/core/lps_pkg.sv
rtl/core/lps_match.sv
rtl/core/lps_scale.sv
rtl/core/logic_pattern_search.sv
tb/tb.sv
